/* rtl/tty_line_discipline_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the line discipline block.
// Both macros expect a clock named clk and an active-low reset named arst_n.
// ----------------------------------------------------------------------------
`ifndef TTY_LINE_DISCIPLINE_TOP_MACROS_SVH
`define TTY_LINE_DISCIPLINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTY_LD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTY_LD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tty_ld_pkg.sv */
// ----------------------------------------------------------------------------
// tty_ld_pkg
// Shared constants, register codes and types of the line discipline block.
// ----------------------------------------------------------------------------
package tty_ld_pkg;

	localparam int LINE_MAX_DEFAULT = 32;
	localparam int BYTE_W           = 8;
	localparam int CFG_DATA_W       = 6;
	localparam int REG_IDX_W        = 2;

	// Register indexes of the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_ECHO_ENABLE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CRLF_IN     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CRLF_OUT    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_READ_LIMIT  = 2'd3;

	// Special bytes.
	localparam logic [BYTE_W-1:0] BYTE_DEL = 8'h7F;
	localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;

	// Result kinds.
	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_LINE = 1'b1;

	// Register values after reset.
	localparam logic                  ECHO_ENABLE_RST = 1'b1;
	localparam logic                  CRLF_IN_RST     = 1'b1;
	localparam logic                  CRLF_OUT_RST    = 1'b1;
	localparam logic [CFG_DATA_W-1:0] READ_LIMIT_RST  = 6'd32;

	typedef struct packed {
		logic                  echo_enable;
		logic                  crlf_in;
		logic                  crlf_out;
		logic [CFG_DATA_W-1:0] read_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDIT,
		ST_STORE,
		ST_ECHO_CR,
		ST_ECHO_CH,
		ST_LINE_PRE,
		ST_LINE
	} state_t;

endpackage

/* rtl/tty_ld_rx_if.sv */
// ----------------------------------------------------------------------------
// tty_ld_rx_if
// Channel for received keyboard bytes.
// ----------------------------------------------------------------------------
interface tty_ld_rx_if;
	import tty_ld_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);

endinterface

/* rtl/tty_ld_res_if.sv */
// ----------------------------------------------------------------------------
// tty_ld_res_if
// Channel for echo bytes and bytes of completed lines.
// ----------------------------------------------------------------------------
interface tty_ld_res_if;
	import tty_ld_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source (output valid, output kind, output out_byte, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input last, output ready);

endinterface

/* rtl/tty_line_discipline_top.sv */
// ----------------------------------------------------------------------------
// tty_line_discipline_top: canonical line editing of received keyboard bytes.
// With echo on, a byte's echo follows its edit and, for a stored byte, the store write;
// a delete on an empty line emits nothing.
// One byte at a time: the next byte is taken only once the edit, the echo and, on a
// completed line, the drain are through; the drain reads one entry ahead, then sends one
// byte per cycle while the output is not stalled.
// Reset clears the line length, the sequencer and the output; registers go to defaults.
// ----------------------------------------------------------------------------
module tty_line_discipline_top #(
	parameter int LINE_MAX = tty_ld_pkg::LINE_MAX_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tty_ld_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [tty_ld_pkg::CFG_DATA_W-1:0] cfg_data,
	tty_ld_rx_if.sink                         rx,
	tty_ld_res_if.source                      res
);
	import tty_ld_pkg::*;

`include "tty_line_discipline_top_macros.svh"

	localparam int IDX_W = $clog2(LINE_MAX);

	// Configuration registers. The user must write only while the block is idle; the block
	// does not enforce this. Flags are read directly, the read limit latched per byte.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.echo_enable <= ECHO_ENABLE_RST;
			cfg_q.crlf_in     <= CRLF_IN_RST;
			cfg_q.crlf_out    <= CRLF_OUT_RST;
			cfg_q.read_limit  <= READ_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ECHO_ENABLE: cfg_q.echo_enable <= cfg_data[0];
				REG_CRLF_IN:     cfg_q.crlf_in     <= cfg_data[0];
				REG_CRLF_OUT:    cfg_q.crlf_out    <= cfg_data[0];
				REG_READ_LIMIT:  cfg_q.read_limit  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The line store lives in one synchronous RAM. Writes happen only while an
	// item is edited and reads only while a line drains, so the two ports never
	// touch the same entry in the same cycle and need no forwarding. Entries
	// are read only below the line length, so the RAM needs no clearing.
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	tty_ld_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_MAX)
	) u_line_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// The sequencer takes one byte at a time: it applies the edit (one or two
	// store writes, or a length decrement for a delete), emits up to two echo
	// bytes, and on a completed line reads the store back in order. Results go
	// through a single output register, so a waiting result stalls only the
	// sequencer and never loses a transfer.
	tty_ld_ctrl #(
		.LINE_MAX(LINE_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rx       (rx),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// Store writes belong to an item in progress, never to an idle block.
	`TTY_LD_ASSERT_SAME(a_write_only_busy, mem_we, !rx.ready, "line store written while idle")
	// When a new byte is taken, any result still waiting must be the final one of the last byte.
	`TTY_LD_ASSERT_SAME(a_accept_after_last, rx.valid && rx.ready, !res.valid || res.last, "byte accepted before previous results were complete")
	// A transfer on the input starts work, so the next cycle cannot take another.
	`TTY_LD_ASSERT_NEXT(a_one_at_a_time, rx.valid && rx.ready, !rx.ready, "second byte accepted while editing")

endmodule

/* rtl/tty_ld_ram.sv */
// ----------------------------------------------------------------------------
// tty_ld_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tty_ld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/tty_ld_ctrl.sv */
// ----------------------------------------------------------------------------
// tty_ld_ctrl
// Editing sequencer: updates the line store, echoes and drains completed lines.
// ----------------------------------------------------------------------------
module tty_ld_ctrl #(
	parameter int LINE_MAX = tty_ld_pkg::LINE_MAX_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tty_ld_pkg::cfg_t              cfg,
	tty_ld_rx_if.sink                     rx,
	tty_ld_res_if.source                  res,
	output logic                          mem_we,
	output logic [$clog2(LINE_MAX)-1:0]   mem_waddr,
	output logic [tty_ld_pkg::BYTE_W-1:0] mem_wdata,
	output logic [$clog2(LINE_MAX)-1:0]   mem_raddr,
	input  logic [tty_ld_pkg::BYTE_W-1:0] mem_rdata
);
	import tty_ld_pkg::*;

	localparam int IDX_W = $clog2(LINE_MAX);
	localparam int LEN_W = $clog2(LINE_MAX + 1);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LINE_MAX);

	state_t            state_q, state_n;
	logic [BYTE_W-1:0] byte_q, byte_n;
	logic [LEN_W-1:0]  len_q, len_n;
	logic [LEN_W-1:0]  limit_q, limit_n;
	logic [IDX_W-1:0]  idx_q, idx_n;

	logic              res_valid_q, res_valid_n;
	logic              res_kind_q, res_kind_n;
	logic [BYTE_W-1:0] res_byte_q, res_byte_n;
	logic              res_last_q, res_last_n;

	logic             is_del, is_cr, is_lf;
	logic             complete, has_line, can_load, idx_is_last;
	logic [LEN_W:0]   len_plus1;
	logic [LEN_W-1:0] limit_clamp;

	assign is_del      = (byte_q == BYTE_DEL);
	assign is_cr       = (byte_q == BYTE_CR);
	assign is_lf       = (byte_q == BYTE_LF);
	assign len_plus1   = (LEN_W+1)'(len_q) + (LEN_W+1)'(1);
	assign complete    = is_cr || is_lf || (len_q >= limit_q);
	assign has_line    = complete && (len_q != '0);
	assign can_load    = !res_valid_q || res.ready;
	assign idx_is_last = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);

	// A limit of zero acts as one; a limit above the store depth acts as the depth.
	always_comb begin
		if (cfg.read_limit == '0) begin
			limit_clamp = LEN_W'(1);
		end else if (32'(cfg.read_limit) > LINE_MAX) begin
			limit_clamp = MAX_LEN;
		end else begin
			limit_clamp = LEN_W'(cfg.read_limit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			len_q       <= len_n;
			res_valid_q <= res_valid_n;
		end
	end

	always_ff @(posedge clk) begin
		byte_q     <= byte_n;
		limit_q    <= limit_n;
		idx_q      <= idx_n;
		res_kind_q <= res_kind_n;
		res_byte_q <= res_byte_n;
		res_last_q <= res_last_n;
	end

	always_comb begin
		state_n     = state_q;
		byte_n      = byte_q;
		len_n       = len_q;
		limit_n     = limit_q;
		idx_n       = idx_q;
		res_valid_n = res_valid_q && !res.ready;
		res_kind_n  = res_kind_q;
		res_byte_n  = res_byte_q;
		res_last_n  = res_last_q;
		rx.ready    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = len_q[IDX_W-1:0];
		mem_wdata   = byte_q;
		mem_raddr   = idx_q;

		case (state_q)
			ST_IDLE: begin
				rx.ready = 1'b1;
				if (rx.valid) begin
					byte_n  = rx.rx_byte;
					limit_n = limit_clamp;
					state_n = ST_EDIT;
				end
			end
			ST_EDIT: begin
				if (is_del) begin
					if (len_q == '0) begin
						state_n = ST_IDLE;
					end else begin
						len_n   = len_q - LEN_W'(1);
						state_n = ST_ECHO_CR;
					end
				end else if (is_lf && cfg.crlf_in && (len_plus1 < (LEN_W+1)'(limit_q))) begin
					mem_we    = 1'b1;
					mem_wdata = BYTE_CR;
					len_n     = len_plus1[LEN_W-1:0];
					state_n   = ST_STORE;
				end else begin
					state_n = ST_STORE;
				end
			end
			ST_STORE: begin
				if (len_q < MAX_LEN) begin
					mem_we = 1'b1;
					len_n  = len_plus1[LEN_W-1:0];
				end
				state_n = ST_ECHO_CR;
			end
			ST_ECHO_CR: begin
				if (cfg.echo_enable && is_lf && cfg.crlf_out) begin
					if (can_load) begin
						res_valid_n = 1'b1;
						res_kind_n  = KIND_ECHO;
						res_byte_n  = BYTE_CR;
						res_last_n  = 1'b0;
						state_n     = ST_ECHO_CH;
					end
				end else begin
					state_n = ST_ECHO_CH;
				end
			end
			ST_ECHO_CH: begin
				if (!cfg.echo_enable || can_load) begin
					if (cfg.echo_enable) begin
						res_valid_n = 1'b1;
						res_kind_n  = KIND_ECHO;
						res_byte_n  = byte_q;
						res_last_n  = !has_line;
					end
					if (has_line) begin
						state_n = ST_LINE_PRE;
					end else begin
						if (complete) begin
							len_n = '0;
						end
						state_n = ST_IDLE;
					end
				end
			end
			ST_LINE_PRE: begin
				idx_n     = '0;
				mem_raddr = '0;
				state_n   = ST_LINE;
			end
			ST_LINE: begin
				// Read data always belongs to idx_q; prefetch the next entry on a transfer.
				if (can_load) begin
					res_valid_n = 1'b1;
					res_kind_n  = KIND_LINE;
					res_byte_n  = mem_rdata;
					res_last_n  = idx_is_last;
					idx_n       = idx_q + IDX_W'(1);
					mem_raddr   = idx_q + IDX_W'(1);
					if (idx_is_last) begin
						len_n   = '0;
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign res.valid    = res_valid_q;
	assign res.kind     = res_kind_q;
	assign res.out_byte = res_byte_q;
	assign res.last     = res_last_q;

endmodule

/* tb/tb_tty_line_discipline_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tty_line_discipline_top
// Self-checking bench for the canonical line editor. A driver and a monitor
// run as clocked processes around the block, and an in-bench predictor of the
// line editing builds the expected echo and line bytes for every accepted
// keyboard byte. Directed edits come first, then random lines under several
// register settings and several patterns of source and sink idling.
// ----------------------------------------------------------------------------
module tb_tty_line_discipline_top;
	import tty_ld_pkg::*;

	localparam int LINE_MAX      = LINE_MAX_DEFAULT;
	// Quiet cycles that outlast the work on a keyboard byte that emits nothing,
	// so this many quiet cycles means the block has truly gone idle.
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int TIMEOUT_NS    = 16_000_000;

	// One emitted byte: an echo for the display or a byte of a finished line.
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} line_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tty_ld_rx_if  rx_ch ();
	tty_ld_res_if res_ch ();

	tty_line_discipline_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch.sink),
		.res       (res_ch.source)
	);

	// Keyboard bytes waiting for the driver, and the bytes the block owes us.
	logic [BYTE_W-1:0] rx_pending [$];
	line_out_t         line_out_exp [$];
	line_out_t         want;

	// Our own copy of the line being edited and of the register settings.
	logic [BYTE_W-1:0]     line_buf [LINE_MAX];
	int                    line_len;
	logic                  echo_on;
	logic                  crlf_in_on;
	logic                  crlf_out_on;
	logic [CFG_DATA_W-1:0] limit_reg;

	// Idling percentages for the current phase and the long sink hold-off.
	int   src_idle_pct;
	int   snk_stall_pct;
	logic hold_req;
	logic hold_active;

	int faults;
	int bytes_queued;
	int bytes_taken;
	int lines_done;
	int echo_bytes_seen;
	int line_bytes_seen;
	int phases_run;

	// 50 MHz clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Any run that outlives this bound has hung somewhere.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout: %0d of %0d keyboard bytes taken, %0d results still owed",
			bytes_taken, bytes_queued, line_out_exp.size());
		$display("TEST FAILED");
		$finish;
	end

	// The first ten faults are described in full; the rest are only counted.
	task automatic report_fault(input string what);
		faults++;
		if (faults <= 10) begin
			$display("[%0t] MISMATCH: %s", $realtime, what);
		end
	endtask

	// Appends one byte to the line copy. The limit never lets the line grow
	// past a full store, but the guard keeps the copy honest if it ever did.
	function automatic void store_char(input logic [BYTE_W-1:0] ch);
		if (line_len < LINE_MAX) begin
			line_buf[line_len] = ch;
			line_len++;
		end
	endfunction

	// Applies one keyboard byte to the line copy and queues every byte that
	// the block must emit for it: the echo first, then a finished line.
	function automatic void edit_line(input logic [BYTE_W-1:0] ch);
		int        lim;
		line_out_t outs [$];

		// A limit of zero behaves as one, and anything past the store size
		// behaves as the store size.
		lim = int'(limit_reg);
		if (lim == 0) begin
			lim = 1;
		end
		if (lim > LINE_MAX) begin
			lim = LINE_MAX;
		end

		if (ch == BYTE_DEL) begin
			// A delete on an empty line is dropped silently, without an echo.
			if (line_len == 0) begin
				return;
			end
			line_len--;
		end else if (ch == BYTE_LF) begin
			// The CR goes in ahead of the LF only if both still fit.
			if (crlf_in_on && line_len + 1 < lim) begin
				store_char(BYTE_CR);
			end
			store_char(BYTE_LF);
		end else begin
			store_char(ch);
		end

		if (echo_on) begin
			if (ch == BYTE_LF && crlf_out_on) begin
				outs.push_back('{kind: KIND_ECHO, data: BYTE_CR, last: 1'b0});
			end
			outs.push_back('{kind: KIND_ECHO, data: ch, last: 1'b0});
		end

		// The line ends on CR or LF, or once it has reached the limit. The
		// last check also catches a limit lowered below a partial line.
		if (ch == BYTE_CR || ch == BYTE_LF || line_len >= lim) begin
			for (int i = 0; i < line_len; i++) begin
				outs.push_back('{kind: KIND_LINE, data: line_buf[i], last: 1'b0});
			end
			line_len = 0;
			lines_done++;
		end

		if (outs.size() > 0) begin
			outs[outs.size() - 1].last = 1'b1;
		end
		foreach (outs[i]) begin
			line_out_exp.push_back(outs[i]);
		end
	endfunction

	// Driver: keeps an offered byte steady until its transfer, then offers
	// the next pending byte unless the source chooses to idle this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= '0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				edit_line(rx_ch.rx_byte);
				bytes_taken++;
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (rx_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= rx_pending.pop_front();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every result transfer against the oldest expected byte,
	// then decides whether the sink stalls in the coming cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (line_out_exp.size() == 0) begin
					report_fault($sformatf("unexpected result kind=%0d byte=%02h last=%0d",
						res_ch.kind, res_ch.out_byte, res_ch.last));
				end else begin
					want = line_out_exp.pop_front();
					if (res_ch.kind !== want.kind || res_ch.out_byte !== want.data ||
					    res_ch.last !== want.last) begin
						report_fault($sformatf(
							"expected kind=%0d byte=%02h last=%0d, got kind=%0d byte=%02h last=%0d",
							want.kind, want.data, want.last,
							res_ch.kind, res_ch.out_byte, res_ch.last));
					end
					if (want.kind == KIND_LINE) begin
						line_bytes_seen++;
					end else begin
						echo_bytes_seen++;
					end
				end
			end
			res_ch.ready <= !hold_active && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Long sink hold-off: once asked for, the sink refuses results for a
	// fixed stretch while the source keeps offering bytes, so the block backs
	// up and has to stall its input.
	initial begin
		hold_active = 1'b0;
		wait (hold_req);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	task automatic queue_byte(input logic [BYTE_W-1:0] b);
		rx_pending.push_back(b);
		bytes_queued++;
	endtask

	// One typed line: mostly printable text with some deletes and a few raw
	// bytes, usually closed by CR or LF, sometimes left to run into the limit.
	task automatic queue_line(input int max_len);
		int len;
		int pick;

		len = $urandom_range(max_len, 1);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				queue_byte(BYTE_W'($urandom_range(8'h7E, 8'h20)));
			end else if (pick < 87) begin
				queue_byte(BYTE_DEL);
			end else begin
				queue_byte(BYTE_W'($urandom_range(255)));
			end
		end
		pick = $urandom_range(99);
		if (pick < 45) begin
			queue_byte(BYTE_CR);
		end else if (pick < 85) begin
			queue_byte(BYTE_LF);
		end
	endtask

	// Mostly well-formed lines, with a stray random byte now and then.
	task automatic queue_random_text(input int n_items, input int max_len);
		int start;

		start = bytes_queued;
		while (bytes_queued - start < n_items) begin
			if ($urandom_range(9) == 0) begin
				queue_byte(BYTE_W'($urandom_range(255)));
			end else begin
				queue_line(max_len);
			end
		end
	endtask

	// Blocks until every queued byte has gone through and every expected
	// result has come out, then lets the block settle.
	task automatic wait_idle();
		do @(negedge clk);
		while (rx_pending.size() != 0 || rx_ch.valid || line_out_exp.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// A register write lands on the next rising edge. The one-bit registers
	// get random upper data bits, which the block has to ignore.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_ECHO_ENABLE: begin
				echo_on = val[0];
			end
			REG_CRLF_IN: begin
				crlf_in_on = val[0];
			end
			REG_CRLF_OUT: begin
				crlf_out_on = val[0];
			end
			REG_READ_LIMIT: begin
				limit_reg = val;
			end
			default: begin
			end
		endcase
	endtask

	// Waits for the block to go idle, loads all four registers and selects
	// the idling pattern of the next phase.
	task automatic start_phase(input logic echo, input logic crlf_i, input logic crlf_o,
	                           input logic [CFG_DATA_W-1:0] limit,
	                           input int src_pct, input int snk_pct);
		wait_idle();
		write_reg(REG_ECHO_ENABLE, {5'($urandom_range(31)), echo});
		write_reg(REG_CRLF_IN, {5'($urandom_range(31)), crlf_i});
		write_reg(REG_CRLF_OUT, {5'($urandom_range(31)), crlf_o});
		write_reg(REG_READ_LIMIT, limit);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		phases_run++;
	endtask

	initial begin
		// Every input of the block has a known value from time zero on.
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		hold_req      = 1'b0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;

		faults          = 0;
		bytes_queued    = 0;
		bytes_taken     = 0;
		lines_done      = 0;
		echo_bytes_seen = 0;
		line_bytes_seen = 0;
		phases_run      = 0;

		// Register defaults after reset; the line starts out empty.
		line_len    = 0;
		echo_on     = ECHO_ENABLE_RST;
		crlf_in_on  = CRLF_IN_RST;
		crlf_out_on = CRLF_OUT_RST;
		limit_reg   = READ_LIMIT_RST;
		foreach (line_buf[i]) begin
			line_buf[i] = '0;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default settings: byte extremes, a delete mid-line, a CR end, a
		// delete on an empty line, an LF end with room for CR LF, and an LF
		// alone on an empty line.
		start_phase(1'b1, 1'b1, 1'b1, 6'd32, 0, 0);
		queue_byte(8'h61);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h80);
		queue_byte(BYTE_DEL);
		queue_byte(BYTE_CR);
		queue_byte(BYTE_DEL);
		queue_byte(8'h55);
		queue_byte(BYTE_LF);
		queue_byte(BYTE_LF);

		// Echo off and a limit of three: an LF that finds no room for the CR
		// is stored alone, and a plain line is forced out at the limit.
		start_phase(1'b0, 1'b1, 1'b0, 6'd3, 0, 0);
		queue_byte(8'h41);
		queue_byte(8'h42);
		queue_byte(BYTE_LF);
		queue_byte(8'h41);
		queue_byte(8'h42);
		queue_byte(8'h43);

		// A limit of zero behaves as one: every stored byte ends its line.
		start_phase(1'b1, 1'b0, 1'b1, 6'd0, 0, 0);
		queue_byte(BYTE_LF);
		queue_byte(8'h31);
		queue_byte(BYTE_DEL);

		// A limit past the store size, then lowered under a partial line:
		// the next delete shortens the line and still forces it out.
		start_phase(1'b1, 1'b1, 1'b1, 6'd63, 0, 0);
		queue_byte(8'h31);
		queue_byte(8'h32);
		queue_byte(8'h33);
		queue_byte(8'h34);
		queue_byte(8'h35);
		start_phase(1'b1, 1'b1, 1'b1, 6'd2, 0, 0);
		queue_byte(BYTE_DEL);

		// Random text under varied settings and idling patterns.
		start_phase(1'b1, 1'b1, 1'b1, 6'd32, 0, 0);
		queue_random_text(75, 36);
		start_phase(1'b0, 1'b0, 1'b0, 6'd8, 60, 0);
		queue_random_text(75, 10);
		start_phase(1'b1, 1'b1, 1'b0, 6'd1, 0, 60);
		queue_random_text(75, 3);
		start_phase(1'b1, 1'b0, 1'b1, 6'd40, 15, 15);
		queue_random_text(75, 36);

		// Back-pressure: the sink holds off for a long stretch while the
		// source offers bytes with no gaps at all.
		start_phase(1'b1, 1'b1, 1'b1, 6'd20, 0, 0);
		hold_req = 1'b1;
		queue_random_text(75, 24);

		// A few phases with fully random settings, the limit drawn from its whole range.
		for (int k = 0; k < 3; k++) begin
			start_phase(1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1)), CFG_DATA_W'($urandom_range(63)), 15, 15);
			queue_random_text(25, 36);
		end

		wait_idle();
		if (line_out_exp.size() != 0) begin
			report_fault($sformatf("%0d expected results never arrived", line_out_exp.size()));
		end

		$display("Run covered %0d keyboard bytes over %0d register settings.",
			bytes_taken, phases_run);
		$display("Checked %0d echo bytes and %0d line bytes in %0d completed lines.",
			echo_bytes_seen, line_bytes_seen, lines_done);
		if (faults == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches in total", faults);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
